@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ITA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ITA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ita_pkg.sv @@
package ita_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_OCT  = 2'd2;
  localparam logic [1:0] OP_HEX  = 2'd3;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_ALPHA = 8'h37;  // 'A' - 10
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [1:0] op;
  } ita_ctrl_t;

  typedef struct packed {
    logic done;
    logic neg;
  } ita_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {4'd0, d};
    end else begin
      c = ASCII_ALPHA + {4'd0, d};
    end
    return c;
  endfunction

endpackage

@@ rtl/core/ita_conv.sv @@
`include "assert_macros.svh"

module ita_conv #(
  parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEF,
  parameter int NDIG        = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ita_pkg::ita_ctrl_t      ctrl,
  input  logic [VALUE_WIDTH-1:0]  value,
  input  logic [$clog2(NDIG)-1:0] rd_idx,
  output logic [3:0]              rd_digit,
  output ita_pkg::ita_stat_t      stat
);
  import ita_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam int DW = 4 * NDIG;

  logic [DW-1:0]          digits_r, digits_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;

  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [3*NDIG-1:0]      pad3;
  logic [DW-1:0]          pad4;
  logic [DW-1:0]          oct_digits;
  logic [DW-1:0]          adj;

  always_comb begin
    neg_in = (ctrl.op == OP_SDEC) && value[VALUE_WIDTH-1];
    mag_in = neg_in ? ('0 - value) : value;
    pad3   = (3*NDIG)'(value);
    pad4   = DW'(value);
    for (int i = 0; i < NDIG; i++) begin
      oct_digits[4*i +: 4] = {1'b0, pad3[3*i +: 3]};
      adj[4*i +: 4] = (digits_r[4*i +: 4] >= 4'd5) ? (digits_r[4*i +: 4] + 4'd3)
                                                   : digits_r[4*i +: 4];
    end
  end

  // shift-add-3 binary to BCD, one bit per step
  always_comb begin
    digits_nxt = digits_r;
    mag_nxt    = mag_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    if (ctrl.load) begin
      neg_nxt = neg_in;
      mag_nxt = mag_in;
      cnt_nxt = CW'(VALUE_WIDTH);
      case (ctrl.op)
        OP_OCT:  digits_nxt = oct_digits;
        OP_HEX:  digits_nxt = pad4;
        default: digits_nxt = '0;
      endcase
    end else if (ctrl.step) begin
      digits_nxt = {adj[DW-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt    = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      neg_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      neg_r <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
    mag_r    <= mag_nxt;
  end

  assign rd_digit  = digits_r[4*rd_idx +: 4];
  assign stat.done = (cnt_r == '0);
  assign stat.neg  = neg_r;

  `ITA_ASSERT(a_step_not_done, ctrl.step |-> (cnt_r != '0), "step issued after conversion done")
  `ITA_ASSERT(a_load_count, ctrl.load |=> (cnt_r == CW'(VALUE_WIDTH)), "bit count not loaded")

endmodule

@@ rtl/core/integer_to_ascii_radix_unit.sv @@
// Converts one VALUE_WIDTH-bit value to ASCII (unsigned/signed decimal, octal,
// uppercase hex), one character per out_valid strobe, most significant first,
// '-' first for a negative signed value, out_last on the final character.
// Each character is on the out_ ports for exactly one cycle; the receiver
// cannot stall, so it must take every strobe. busy is high from the accepting
// edge until the final character is registered. After the accepting edge,
// decimal runs a shift-add-3 conversion (one bit per cycle through the
// per-digit add-3 adjusters), octal and hex need none; then the leading zero
// digits are skipped, keeping at least one, and the characters are emitted.
`include "assert_macros.svh"

module integer_to_ascii_radix_unit #(
  parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic [1:0]             in_opcode,
  output logic                   out_valid,
  output logic [7:0]             out_ascii_char,
  output logic                   out_last
);
  import ita_pkg::*;

  localparam int NDIG_DEC = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NDIG_OCT = (VALUE_WIDTH + 2) / 3;
  localparam int NDIG     = (NDIG_DEC > NDIG_OCT) ? NDIG_DEC : NDIG_OCT;
  localparam int IDXW     = $clog2(NDIG);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [IDXW-1:0] ptr_r, ptr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;

  ita_ctrl_t  ctrl;
  ita_stat_t  stat;
  logic [3:0] rd_digit;

  ita_conv #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NDIG       (NDIG)
  ) u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .value   (in_value),
    .rd_idx  (ptr_r),
    .rd_digit(rd_digit),
    .stat    (stat)
  );

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctrl.load     = 1'b0;
    ctrl.step     = 1'b0;
    ctrl.op       = in_opcode;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          ptr_nxt   = IDXW'(NDIG - 1);
          state_nxt = (in_opcode == OP_UDEC || in_opcode == OP_SDEC) ? ST_CONV : ST_SKIP;
        end
      end
      ST_CONV: begin
        if (stat.done) begin
          state_nxt = ST_SKIP;
        end else begin
          ctrl.step = 1'b1;
        end
      end
      ST_SKIP: begin
        if (ptr_r != '0 && rd_digit == 4'd0) begin
          ptr_nxt = ptr_r - 1'b1;
        end else begin
          state_nxt = stat.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = ASCII_MINUS;
        out_last_nxt  = 1'b0;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = digit_char(rd_digit);
        out_last_nxt  = (ptr_r == '0);
        if (ptr_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last       = out_last_r;

  `ITA_ASSERT(a_out_from_busy, out_valid |-> $past(busy), "item strobe without work in flight")
  `ITA_ASSERT(a_last_ends, (out_valid && out_last) |=> !out_valid, "strobe after final char")
  `ITA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  `ITA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!busy && !out_valid), "reset left unit active")

endmodule

@@ sim/integer_to_ascii_radix_unit_tb.sv @@
module integer_to_ascii_radix_unit_tb;
  import ita_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_value = '0;
  logic [1:0]  in_opcode = OP_UDEC;
  logic        out_valid;
  logic [7:0]  out_ascii_char;
  logic        out_last;

  text_char_t pending_chars[$];
  text_char_t want;
  int unsigned mismatches = 0;
  bit          idle_enable = 1'b1;

  integer_to_ascii_radix_unit #(.VALUE_WIDTH(32)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_opcode     (in_opcode),
    .out_valid     (out_valid),
    .out_ascii_char(out_ascii_char),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Expected text of one number, most significant character first.
  function automatic void predict_text(input logic [31:0] value, input logic [1:0] opcode);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [3:0]  digits[0:31];
    int          nd;
    text_char_t  c;
    mag = value;
    nd = 0;
    case (opcode)
      OP_OCT:  radix = 32'd8;
      OP_HEX:  radix = 32'd16;
      default: radix = 32'd10;
    endcase
    if (opcode == OP_SDEC && value[31]) begin
      mag = -value;
      c.ch = ASCII_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    do begin
      digits[nd] = 4'(mag % radix);
      nd++;
      mag = mag / radix;
    end while (mag != 0);
    for (int i = nd - 1; i >= 0; i--) begin
      if (digits[i] < 4'd10) begin
        c.ch = ASCII_ZERO + 8'(digits[i]);
      end else begin
        c.ch = "A" + 8'(digits[i]) - 8'd10;
      end
      c.last = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // Entered and left at a rising edge; the exit edge is the accepting one.
  task automatic send_number(input logic [31:0] value, input logic [1:0] opcode);
    int gap;
    gap = idle_enable ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value <= value;
    in_opcode <= opcode;
    do @(posedge clk); while (busy);
    predict_text(value, opcode);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char %h last %b", out_ascii_char, out_last);
      end else begin
        want = pending_chars.pop_front();
        if (out_ascii_char !== want.ch || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("char exp %h last %b, got %h last %b",
                     want.ch, want.last, out_ascii_char, out_last);
        end
      end
    end
  end

  task automatic test_zero_all_radices();
    send_number(32'd0, OP_UDEC);
    send_number(32'd0, OP_SDEC);
    send_number(32'd0, OP_OCT);
    send_number(32'd0, OP_HEX);
  endtask

  task automatic test_value_extremes();
    send_number(32'hFFFF_FFFF, OP_UDEC);
    send_number(32'hFFFF_FFFF, OP_SDEC);
    send_number(32'hFFFF_FFFF, OP_OCT);
    send_number(32'hFFFF_FFFF, OP_HEX);
    send_number(32'h8000_0000, OP_SDEC);
    send_number(32'h8000_0000, OP_UDEC);
    send_number(32'h7FFF_FFFF, OP_SDEC);
    send_number(32'h8000_0001, OP_SDEC);
    send_number(32'h4000_0000, OP_OCT);
  endtask

  task automatic test_digit_boundaries();
    send_number(32'd1, OP_UDEC);
    send_number(32'd9, OP_UDEC);
    send_number(32'd10, OP_SDEC);
    send_number(32'd7, OP_OCT);
    send_number(32'd8, OP_OCT);
    send_number(32'd15, OP_HEX);
    send_number(32'd16, OP_HEX);
    send_number(32'hABCD_EF09, OP_HEX);
    send_number(32'd1_000_000_000, OP_UDEC);
    send_number(32'hFFFF_FFF6, OP_SDEC);
  endtask

  task automatic test_random_numbers();
    logic [31:0] value;
    for (int i = 0; i < 260; i++) begin
      if (i % 20 == 0) idle_enable = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: value = $urandom;
        1: value = $urandom_range(0, 1000);
        2: value = $urandom >> $urandom_range(0, 31);
        default: value = ~($urandom >> $urandom_range(0, 31));
      endcase
      send_number(value, 2'($urandom_range(0, 3)));
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_all_radices();
    test_value_extremes();
    test_digit_boundaries();
    test_random_numbers();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ita_pkg.sv
rtl/core/ita_conv.sv
rtl/core/integer_to_ascii_radix_unit.sv
sim/integer_to_ascii_radix_unit_tb.sv
